/* sv/clnf_pkg.sv */
// shared types, codes and constants of the color neighborhood flatness test
package clnf_pkg;

    // channel and field widths fixed by the item format
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned NUM_CHAN    = 3;
    localparam int unsigned COUNT_OUT_W = 7;
    localparam int unsigned S_DATA_W    = 24;
    localparam int unsigned M_DATA_W    = 16;
    localparam int unsigned STEP_W      = 4;

    // tolerance after reset
    localparam logic [CHAN_W-1:0] TOL_RESET = 8'd5;

    // item kinds on the input tuser bit
    localparam logic OP_NEIGHBOUR = 1'b0;
    localparam logic OP_VERTEX    = 1'b1;

    // last sequencer step of each item kind
    localparam logic [STEP_W-1:0] NBR_LAST = 4'd2;
    localparam logic [STEP_W-1:0] VTX_LAST = 4'd12;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NBR,
        ST_VTX,
        ST_FINAL,
        ST_FLUSH
    } state_t;

    // micro-operations of the shared multiplier
    typedef enum logic [2:0] {
        UOP_SQ,     // color byte squared, added to the square sum
        UOP_TT,     // tolerance squared
        UOP_NN1,    // n * (n - 1)
        UOP_TN,     // tolerance * n
        UOP_BOUND,  // t^2 * n * (n - 1)
        UOP_NQ,     // n * square sum
        UOP_SS,     // sum squared, closes the spread test
        UOP_NC      // n * centre, closes the mean test
    } uop_kind_t;

    typedef struct packed {
        uop_kind_t  kind;
        logic [1:0] ch;
    } uop_t;

    // sequencer to datapath control
    typedef struct packed {
        logic issue_valid;
        uop_t issue_op;
        logic cons_valid;
        uop_t cons_op;
        logic load_out;
        logic idle;
    } ctrl_t;

    // micro-program of a vertex item
    function automatic uop_t vtx_uop(input logic [STEP_W-1:0] step);
        uop_t u;
        u.ch = 2'd0;
        unique case (step)
            4'd0:  u.kind = UOP_TT;
            4'd1:  u.kind = UOP_NN1;
            4'd2:  u.kind = UOP_TN;
            4'd3:  u.kind = UOP_BOUND;
            4'd4:  begin u.kind = UOP_NQ; u.ch = 2'd0; end
            4'd5:  begin u.kind = UOP_SS; u.ch = 2'd0; end
            4'd6:  begin u.kind = UOP_NC; u.ch = 2'd0; end
            4'd7:  begin u.kind = UOP_NQ; u.ch = 2'd1; end
            4'd8:  begin u.kind = UOP_SS; u.ch = 2'd1; end
            4'd9:  begin u.kind = UOP_NC; u.ch = 2'd1; end
            4'd10: begin u.kind = UOP_NQ; u.ch = 2'd2; end
            4'd11: begin u.kind = UOP_SS; u.ch = 2'd2; end
            4'd12: begin u.kind = UOP_NC; u.ch = 2'd2; end
            default: u.kind = UOP_TT;
        endcase
        return u;
    endfunction

endpackage

/* sv/color_neighborhood_flatness_test_top.sv */
// top level of the color neighborhood flatness test
//
// A neighbour transfer (tuser 0) adds its red, green and blue bytes into
// per-channel sums and sums of squares; s_tready drops while the
// single shared multiplier squares the three bytes. A vertex transfer
// (tuser 1) runs a 13-step program on the same multiplier (tolerance terms,
// then n*Q, S*S and n*centre per channel), then passes ST_FINAL and ST_FLUSH;
// in ST_FLUSH the result waits for the previous one to leave the output
// register, and no transfer is accepted while a result
// waits. The vertex result carries removable, the neighbour count (low 7
// bits) and the overflow flag, and clears the accumulators. Neighbours beyond
// MAX_NEIGHBOURS are dropped while s_tready stays high and flag overflow. cfg_we writes the
// tolerance (reset 5); write it only while the block is idle.
module color_neighborhood_flatness_test_top #(
    parameter int unsigned MAX_NEIGHBOURS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tolerance register write
    input  logic                          cfg_we,
    input  logic [clnf_pkg::CHAN_W-1:0]   cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [clnf_pkg::S_DATA_W-1:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic [0:0]                    s_tuser,   // operation[0]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [clnf_pkg::M_DATA_W-1:0] m_tdata    // removable[0], neighbour_count[7:1],
                                                     // overflow[8], zero[15:9]
);

    localparam int unsigned CW   = $clog2(MAX_NEIGHBOURS + 1);
    localparam int unsigned SW   = $clog2(255 * MAX_NEIGHBOURS + 1);
    localparam int unsigned QW   = $clog2(65025 * MAX_NEIGHBOURS + 1);
    localparam int unsigned MW   = (QW > 2 * CW) ? QW : 2 * CW;
    localparam int unsigned PW   = 2 * MW;
    localparam int unsigned TTW  = 2 * clnf_pkg::CHAN_W;
    localparam int unsigned NN1W = 2 * CW;
    localparam int unsigned TNW  = clnf_pkg::CHAN_W + CW;
    localparam int unsigned BW   = TTW + NN1W;
    localparam int unsigned NQW  = CW + QW;
    localparam int unsigned CMPW = (NQW > BW) ? NQW : BW;

    clnf_pkg::ctrl_t             ctrl;
    logic [clnf_pkg::CHAN_W-1:0] tol_reg;
    logic [clnf_pkg::CHAN_W-1:0] pix_reg [clnf_pkg::NUM_CHAN];
    logic [SW-1:0]               sum_reg [clnf_pkg::NUM_CHAN];
    logic [QW-1:0]               sq_reg  [clnf_pkg::NUM_CHAN];
    logic [CW-1:0]               n_reg;
    logic                        ovf_reg;
    logic                        ok_reg;
    logic [TTW-1:0]              tt_reg;
    logic [NN1W-1:0]             nn1_reg;
    logic [TNW-1:0]              tn_reg;
    logic [BW-1:0]               bound_reg;
    logic [NQW-1:0]              nq_reg;
    logic [SW-1:0]               sel_sum_reg;
    logic                        m_tvalid_reg;
    logic [clnf_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic                        s_accept;
    logic                        is_vertex;
    logic                        full;
    logic                        start_nbr;
    logic                        start_vtx;
    logic                        out_free;
    logic [MW-1:0]               op_a;
    logic [MW-1:0]               op_b;
    logic [PW-1:0]               prod;
    logic [NQW-1:0]              spread;
    logic [SW-1:0]               nc;
    logic [SW-1:0]               diff;
    logic [1:0]                  ich;

    // input handshake and item decode
    assign s_tready  = ctrl.idle;
    assign s_accept  = s_tvalid && s_tready;
    assign is_vertex = (s_tuser[0] == clnf_pkg::OP_VERTEX);
    assign full      = (n_reg >= CW'(MAX_NEIGHBOURS));
    assign start_nbr = s_accept && !is_vertex && !full;
    assign start_vtx = s_accept && is_vertex;
    assign out_free  = !m_tvalid_reg || m_tready;

    clnf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_nbr (start_nbr),
        .start_vtx (start_vtx),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    // operand selection for the shared multiplier
    assign ich = ctrl.issue_op.ch;
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ctrl.issue_op.kind)
            clnf_pkg::UOP_SQ: begin
                op_a = MW'(pix_reg[ich]);
                op_b = MW'(pix_reg[ich]);
            end
            clnf_pkg::UOP_TT: begin
                op_a = MW'(tol_reg);
                op_b = MW'(tol_reg);
            end
            clnf_pkg::UOP_NN1: begin
                op_a = MW'(n_reg);
                op_b = MW'(n_reg - CW'(1));
            end
            clnf_pkg::UOP_TN: begin
                op_a = MW'(tol_reg);
                op_b = MW'(n_reg);
            end
            clnf_pkg::UOP_BOUND: begin
                op_a = MW'(tt_reg);
                op_b = MW'(nn1_reg);
            end
            clnf_pkg::UOP_NQ: begin
                op_a = MW'(n_reg);
                op_b = MW'(sq_reg[ich]);
            end
            clnf_pkg::UOP_SS: begin
                op_a = MW'(sum_reg[ich]);
                op_b = MW'(sum_reg[ich]);
            end
            clnf_pkg::UOP_NC: begin
                op_a = MW'(n_reg);
                op_b = MW'(pix_reg[ich]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    clnf_mul #(
        .WIDTH (MW)
    ) u_mul (
        .aclk (aclk),
        .en   (ctrl.issue_valid),
        .a    (op_a),
        .b    (op_b),
        .p    (prod)
    );

    // spread and centre-to-mean distance from the returned product
    assign spread = nq_reg - prod[NQW-1:0];
    assign nc     = prod[SW-1:0];
    assign diff   = (sel_sum_reg >= nc) ? (sel_sum_reg - nc) : (nc - sel_sum_reg);

    // tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= clnf_pkg::TOL_RESET;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    // color bytes of the accepted transfer
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_reg[0] <= s_tdata[7:0];
            pix_reg[1] <= s_tdata[15:8];
            pix_reg[2] <= s_tdata[23:16];
        end
    end

    // latch the sum of the issued channel for the mean test
    always_ff @(posedge aclk) begin
        if (ctrl.issue_valid) begin
            sel_sum_reg <= sum_reg[ich];
        end
    end

    // accumulators, count and overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.load_out) begin
            for (int i = 0; i < clnf_pkg::NUM_CHAN; i++) begin
                sum_reg[i] <= '0;
                sq_reg[i]  <= '0;
            end
            n_reg   <= '0;
            ovf_reg <= 1'b0;
        end else begin
            if (start_nbr) begin
                sum_reg[0] <= sum_reg[0] + SW'(s_tdata[7:0]);
                sum_reg[1] <= sum_reg[1] + SW'(s_tdata[15:8]);
                sum_reg[2] <= sum_reg[2] + SW'(s_tdata[23:16]);
                n_reg      <= n_reg + CW'(1);
            end
            if (s_accept && !is_vertex && full) begin
                ovf_reg <= 1'b1;
            end
            for (int i = 0; i < clnf_pkg::NUM_CHAN; i++) begin
                if (ctrl.cons_valid && ctrl.cons_op.kind == clnf_pkg::UOP_SQ
                    && ctrl.cons_op.ch == 2'(i)) begin
                    sq_reg[i] <= sq_reg[i] + QW'(prod[TTW-1:0]);
                end
            end
        end
    end

    // closing test terms and the running pass flag
    always_ff @(posedge aclk) begin
        if (start_vtx) begin
            ok_reg <= !ovf_reg && (n_reg >= CW'(2));
        end else if (ctrl.cons_valid) begin
            case (ctrl.cons_op.kind)
                clnf_pkg::UOP_TT:    tt_reg    <= prod[TTW-1:0];
                clnf_pkg::UOP_NN1:   nn1_reg   <= prod[NN1W-1:0];
                clnf_pkg::UOP_TN:    tn_reg    <= prod[TNW-1:0];
                clnf_pkg::UOP_BOUND: bound_reg <= prod[BW-1:0];
                clnf_pkg::UOP_NQ:    nq_reg    <= prod[NQW-1:0];
                clnf_pkg::UOP_SS: begin
                    if (CMPW'(spread) >= CMPW'(bound_reg)) begin
                        ok_reg <= 1'b0;
                    end
                end
                clnf_pkg::UOP_NC: begin
                    if (TNW'(diff) >= tn_reg) begin
                        ok_reg <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_tdata_reg <= {7'd0, ovf_reg, 7'(n_reg), ok_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // a removable vertex never comes with overflow or a zero neighbour count
    a_removable_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[0]) |-> (!m_tdata_reg[8] && m_tdata_reg[7:1] != 7'd0))
        else $error("removable result with overflow or no neighbours");

    // the count holds at the bound once overflow is flagged
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> full)
        else $error("overflow flagged below the neighbour bound");
`endif

endmodule

/* sv/clnf_mul.sv */
// shared multiplier with registered product
module clnf_mul #(
    parameter int unsigned WIDTH = 22
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [2*WIDTH-1:0] p
);

    logic [2*WIDTH-1:0] p_reg;

    // one product per issued operation
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

/* sv/clnf_ctrl.sv */
// sequencer that steps the shared multiplier through each item
module clnf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start_nbr,
    input  logic                  start_vtx,
    input  logic                  out_free,
    output clnf_pkg::ctrl_t       ctrl
);

    clnf_pkg::state_t                 state_reg, state_next;
    logic [clnf_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                             pend_valid_reg;
    clnf_pkg::uop_t                   pend_op_reg;
    logic                             issue_valid;
    clnf_pkg::uop_t                   issue_op;
    logic                             load_out;
    logic                             idle;

    // state, step and pending operation registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= clnf_pkg::ST_IDLE;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pend_valid_reg <= issue_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_valid) begin
            pend_op_reg <= issue_op;
        end
    end

    // next state and issue decode
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        issue_valid   = 1'b0;
        issue_op.kind = clnf_pkg::UOP_SQ;
        issue_op.ch   = 2'd0;
        load_out      = 1'b0;
        idle          = 1'b0;
        unique case (state_reg)
            clnf_pkg::ST_IDLE: begin
                idle = 1'b1;
                if (start_vtx) begin
                    state_next = clnf_pkg::ST_VTX;
                    step_next  = '0;
                end else if (start_nbr) begin
                    state_next = clnf_pkg::ST_NBR;
                    step_next  = '0;
                end
            end
            clnf_pkg::ST_NBR: begin
                issue_valid   = 1'b1;
                issue_op.kind = clnf_pkg::UOP_SQ;
                issue_op.ch   = step_reg[1:0];
                if (step_reg == clnf_pkg::NBR_LAST) begin
                    state_next = clnf_pkg::ST_IDLE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            clnf_pkg::ST_VTX: begin
                issue_valid = 1'b1;
                issue_op    = clnf_pkg::vtx_uop(step_reg);
                if (step_reg == clnf_pkg::VTX_LAST) begin
                    state_next = clnf_pkg::ST_FINAL;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            clnf_pkg::ST_FINAL: begin
                state_next = clnf_pkg::ST_FLUSH;
            end
            clnf_pkg::ST_FLUSH: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = clnf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = clnf_pkg::ST_IDLE;
            end
        endcase
    end

    assign ctrl.issue_valid = issue_valid;
    assign ctrl.issue_op    = issue_op;
    assign ctrl.cons_valid  = pend_valid_reg;
    assign ctrl.cons_op     = pend_op_reg;
    assign ctrl.load_out    = load_out;
    assign ctrl.idle        = idle;

`ifndef SYNTHESIS
    // a vertex result is loaded only after the closing operation was consumed
    a_load_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !pend_valid_reg)
        else $error("result loaded while an operation is still pending");

    // every issued operation is consumed by the product pipeline in the next cycle
    a_cons_follows_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_valid |=> pend_valid_reg)
        else $error("issued operation was not consumed");

    // a neighbour run ends with the blue square
    a_nbr_last_blue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == clnf_pkg::ST_NBR && step_reg == clnf_pkg::NBR_LAST)
        |-> issue_op.ch == 2'd2)
        else $error("neighbour sequence ended on the wrong channel");
`endif

endmodule
